// File: rtl/dtfb_pkg.sv
// ----------------------------------------------------------------------------
// dtfb_pkg
// Shared types and constants of the DDS tuning frame builder.
// ----------------------------------------------------------------------------
package dtfb_pkg;

  localparam int FREQ_W          = 32;
  localparam int PHASE_IN_W      = 8;
  localparam int PHASE_W         = 5;
  localparam int BYTE_W          = 8;
  localparam int STATUS_W        = 2;
  localparam int FRAME_BYTES     = 5;
  localparam int IDX_W           = $clog2(FRAME_BYTES);
  localparam int DIV_STEPS       = 2 * FREQ_W;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [PHASE_IN_W-1:0] PHASE_MAX = PHASE_IN_W'(31);
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(FRAME_BYTES - 1);

  localparam logic [FREQ_W-1:0] SYSCLK_RESET = FREQ_W'(125000000);
  localparam logic              LATCH_PIN_RESET = 1'b1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_SYSCLK = 1'b0;
  localparam logic REG_LATCH  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PHASE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_LATCH = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] sysclk_hz;
    logic              latch_pin_present;
  } cfg_t;

  // One item in flight through the divider.
  typedef struct packed {
    logic [FREQ_W-1:0]  freq;     // dividend bits still to be shifted in
    logic [FREQ_W-1:0]  rem;      // partial remainder
    logic [FREQ_W-1:0]  quot;     // low quotient bits so far
    logic [PHASE_W-1:0] phase;
    logic               pd_flag;
    logic               latch_request;
    logic               phase_err;
  } div_data_t;

endpackage

// File: rtl/dtfb_if.sv
// ----------------------------------------------------------------------------
// dtfb_in_if / dtfb_out_if
// Valid/ready channels for request items and frame byte items.
// ----------------------------------------------------------------------------
interface dtfb_in_if;
  import dtfb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FREQ_W-1:0]     target_freq;
  logic [PHASE_IN_W-1:0] phase_code;
  logic                  pd_flag;
  logic                  latch_request;

  modport source (output valid, target_freq, phase_code, pd_flag, latch_request,
                  input ready);
  modport sink   (input valid, target_freq, phase_code, pd_flag, latch_request,
                  output ready);
endinterface

interface dtfb_out_if;
  import dtfb_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   frame_byte;
  logic                last_byte;
  logic                pulse_latch;
  logic [STATUS_W-1:0] status;

  modport source (output valid, frame_byte, last_byte, pulse_latch, status,
                  input ready);
  modport sink   (input valid, frame_byte, last_byte, pulse_latch, status,
                  output ready);
endinterface

// File: rtl/dtfb_cfg.sv
// ----------------------------------------------------------------------------
// dtfb_cfg
// APB register file holding the reference clock and the latch pin flag.
// ----------------------------------------------------------------------------
module dtfb_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dtfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dtfb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dtfb_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output dtfb_pkg::cfg_t                 cfg
);
  import dtfb_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sysclk_hz         <= SYSCLK_RESET;
      cfg.latch_pin_present <= LATCH_PIN_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_SYSCLK) begin
        cfg.sysclk_hz <= pwdata[FREQ_W-1:0];
      end else begin
        cfg.latch_pin_present <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_LATCH) begin
      prdata = {{(APB_DATA_W-1){1'b0}}, cfg.latch_pin_present};
    end else begin
      prdata = APB_DATA_W'(cfg.sysclk_hz);
    end
  end

endmodule

// File: rtl/dtfb_div_stage.sv
// ----------------------------------------------------------------------------
// dtfb_div_stage
// One register stage of the restoring divider: STEPS_PER_STAGE shift/subtract steps.
// ----------------------------------------------------------------------------
module dtfb_div_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [dtfb_pkg::FREQ_W-1:0]  sysclk_hz,
  input  logic                         in_valid,
  input  dtfb_pkg::div_data_t          in_data,
  output logic                         out_valid,
  output dtfb_pkg::div_data_t          out_data
);
  import dtfb_pkg::*;

  div_data_t         chain [STEPS_PER_STAGE+1];
  logic [FREQ_W:0]   trial [STEPS_PER_STAGE];
  logic              ge    [STEPS_PER_STAGE];
  logic [FREQ_W:0]   divisor;

  assign divisor = {1'b0, sysclk_hz};

  // The remainder stays below the divisor, so the trial value fits in one
  // extra bit. A zero divisor makes every quotient bit one, which is the
  // saturated tuning word.
  always_comb begin
    chain[0] = in_data;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      trial[i]          = {chain[i].rem, chain[i].freq[FREQ_W-1]};
      ge[i]             = (trial[i] >= divisor);
      chain[i+1]        = chain[i];
      chain[i+1].rem    = ge[i] ? FREQ_W'(trial[i] - divisor) : trial[i][FREQ_W-1:0];
      chain[i+1].freq   = {chain[i].freq[FREQ_W-2:0], 1'b0};
      chain[i+1].quot   = {chain[i].quot[FREQ_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= chain[STEPS_PER_STAGE];
    end
  end

endmodule

// File: rtl/dtfb_serializer.sv
// ----------------------------------------------------------------------------
// dtfb_serializer
// Holds one finished item and sends it out as frame bytes, or as a single
// error item when the phase code was out of range.
// ----------------------------------------------------------------------------
module dtfb_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                latch_pin_present,
  input  logic                in_valid,
  input  dtfb_pkg::div_data_t in_data,
  output logic                in_ready,
  dtfb_out_if.source          out
);
  import dtfb_pkg::*;

  logic               busy;
  logic [IDX_W-1:0]   idx;
  logic [FREQ_W-1:0]  ftw;
  logic [BYTE_W-1:0]  ctrl_byte;
  logic               latch_req;
  logic               phase_err;
  logic               is_last;
  logic               take;
  logic               load;

  assign is_last  = phase_err || (idx == LAST_IDX);
  assign take     = out.valid && out.ready;
  assign in_ready = !busy || (out.ready && is_last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ftw       <= in_data.quot;
      ctrl_byte <= {in_data.phase, in_data.pd_flag, 2'b00};
      latch_req <= in_data.latch_request;
      phase_err <= in_data.phase_err;
    end
  end

  assign out.valid     = busy;
  assign out.last_byte = is_last;

  always_comb begin
    if (phase_err) begin
      out.frame_byte = '0;
    end else if (idx == LAST_IDX) begin
      out.frame_byte = ctrl_byte;
    end else begin
      out.frame_byte = ftw[{idx[1:0], 3'b000} +: BYTE_W];
    end
  end

  always_comb begin
    out.pulse_latch = 1'b0;
    out.status      = STATUS_OK;
    if (phase_err) begin
      out.status = STATUS_PHASE;
    end else if (is_last && latch_req) begin
      if (latch_pin_present) begin
        out.pulse_latch = 1'b1;
      end else begin
        out.status = STATUS_NO_LATCH;
      end
    end
  end

endmodule

// File: rtl/dds_tuning_frame_builder.sv
// ----------------------------------------------------------------------------
// dds_tuning_frame_builder
// Turns a frequency request into a five-byte DDS tuning frame.
// ----------------------------------------------------------------------------
// The block computes the tuning word floor(target_freq * 2^32 / sysclk_hz),
// low 32 bits kept, in a 16-stage restoring divider pipeline (four quotient
// bits per stage) that takes up to one item per cycle while it is not held.
// An item's first byte is offered once it has passed every divider stage and
// been loaded into the serializer. Each item then leaves as five byte items
// (tuning word least significant byte first, then the control byte), or as
// one error item when the phase code exceeds 31; the serializer takes the
// next item as the last byte of the current one is taken. The user must see
// that registers are written over APB only while no item is in flight; the
// block does not enforce it. Address 0: sysclk_hz, 4: latch_pin_present.
module dds_tuning_frame_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dtfb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dtfb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  dtfb_in_if.sink                         in,
  dtfb_out_if.source                      out
);
  import dtfb_pkg::*;

  cfg_t       cfg;
  div_data_t  pipe_data  [DIV_STAGES+1];
  logic       pipe_valid [DIV_STAGES+1];
  logic       ser_ready;
  logic       adv;

  dtfb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The whole pipeline moves together; it holds only when its last stage
  // is full and the serializer cannot take that item.
  assign adv      = !pipe_valid[DIV_STAGES] || ser_ready;
  assign in.ready = adv;

  always_comb begin
    pipe_valid[0]              = in.valid;
    pipe_data[0].freq          = in.target_freq;
    pipe_data[0].rem           = '0;
    pipe_data[0].quot          = '0;
    pipe_data[0].phase         = in.phase_code[PHASE_W-1:0];
    pipe_data[0].pd_flag       = in.pd_flag;
    pipe_data[0].latch_request = in.latch_request;
    pipe_data[0].phase_err     = (in.phase_code > PHASE_MAX);
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    dtfb_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .sysclk_hz (cfg.sysclk_hz),
      .in_valid  (pipe_valid[s]),
      .in_data   (pipe_data[s]),
      .out_valid (pipe_valid[s+1]),
      .out_data  (pipe_data[s+1])
    );
  end

  dtfb_serializer u_ser (
    .clk               (clk),
    .rst               (rst),
    .latch_pin_present (cfg.latch_pin_present),
    .in_valid          (pipe_valid[DIV_STAGES]),
    .in_data           (pipe_data[DIV_STAGES]),
    .in_ready          (ser_ready),
    .out               (out)
  );

endmodule

// File: rtl/dtfb_checker.sv
// ----------------------------------------------------------------------------
// dtfb_checker
// Port-level checks on the frame byte output, bound to the top level.
// ----------------------------------------------------------------------------
module dtfb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dtfb_pkg::BYTE_W-1:0]   out_frame_byte,
  input logic                          out_last_byte,
  input logic                          out_pulse_latch,
  input logic [dtfb_pkg::STATUS_W-1:0] out_status
);
  import dtfb_pkg::*;

  // A phase error is a single item with a zero byte.
  a_phase_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == STATUS_PHASE |-> out_last_byte && out_frame_byte == '0)
    else $error("phase error item is not a single zero byte");

  // A latch pulse only comes on a good last byte.
  a_pulse_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pulse_latch |-> out_last_byte && out_status == STATUS_OK)
    else $error("latch pulse outside a good last byte");

  // Bytes before the last carry no status.
  a_mid_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last_byte |-> out_status == STATUS_OK && !out_pulse_latch)
    else $error("status set on a byte before the last");

  // A stalled byte stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_last_byte))
    else $error("output item changed while stalled");

endmodule

bind dds_tuning_frame_builder dtfb_checker u_dtfb_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out.valid),
  .out_ready       (out.ready),
  .out_frame_byte  (out.frame_byte),
  .out_last_byte   (out.last_byte),
  .out_pulse_latch (out.pulse_latch),
  .out_status      (out.status)
);

// File: dv/tb_dds_tuning_frame_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dds_tuning_frame_builder
// Self-checking bench for the DDS tuning frame builder. A directed table
// covers the register extremes, wrap of the tuning word, the saturating
// divider and the phase and latch errors. Random requests follow under
// several clock settings. Every frame byte is checked against the table or a
// local predictor while both channels stall at random, but in one calm phase.
// ----------------------------------------------------------------------------
module tb_dds_tuning_frame_builder;
  import dtfb_pkg::*;

  typedef struct packed {
    logic [FREQ_W-1:0]     target_freq;
    logic [PHASE_IN_W-1:0] phase_code;
    logic                  pd_flag;
    logic                  latch_request;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   frame_byte;
    logic                last_byte;
    logic                pulse_latch;
    logic [STATUS_W-1:0] status;
  } frame_item_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SETTINGS} row_kind_t;

  // For settings rows, word holds sysclk_hz and pin holds latch_pin_present.
  typedef struct packed {
    row_kind_t           kind;
    request_t            req;
    logic [FREQ_W-1:0]   word;
    logic                pin;
    logic [STATUS_W-1:0] last_status;
    logic                last_pulse;
  } row_t;

  localparam int NUM_ROWS     = 22;
  localparam int RAND_PHASES  = 6;
  localparam int RAND_PER_PHASE = 25;

  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_TYPED,   '{32'd0,         8'd0,   1'b0, 1'b0}, 32'h0000_0000, 1'b0, STATUS_OK, 1'b0},
    '{ROW_TYPED,   '{32'd62500000,  8'd31,  1'b1, 1'b1}, 32'h8000_0000, 1'b0, STATUS_OK, 1'b1},
    '{ROW_TYPED,   '{32'd125000000, 8'd0,   1'b0, 1'b0}, 32'h0000_0000, 1'b0, STATUS_OK, 1'b0},
    '{ROW_PREDICT, '{32'hFFFF_FFFF, 8'd16,  1'b0, 1'b1}, 32'h0,         1'b0, STATUS_OK, 1'b0},
    '{ROW_PREDICT, '{32'd1,         8'd1,   1'b1, 1'b0}, 32'h0,         1'b0, STATUS_OK, 1'b0},
    '{ROW_TYPED,   '{32'h1234_5678, 8'd32,  1'b0, 1'b0}, 32'h0,         1'b0, STATUS_PHASE, 1'b0},
    '{ROW_TYPED,   '{32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1}, 32'h0,         1'b0, STATUS_PHASE, 1'b0},
    '{ROW_TYPED,   '{32'd31250000,  8'd10,  1'b0, 1'b1}, 32'h4000_0000, 1'b0, STATUS_OK, 1'b1},
    '{ROW_SETTINGS, '{32'd0, 8'd0, 1'b0, 1'b0},          32'd0,         1'b0, STATUS_OK, 1'b0},
    '{ROW_TYPED,   '{32'd12345,     8'd5,   1'b0, 1'b1}, 32'hFFFF_FFFF, 1'b0, STATUS_NO_LATCH, 1'b0},
    '{ROW_TYPED,   '{32'd0,         8'd31,  1'b1, 1'b0}, 32'hFFFF_FFFF, 1'b0, STATUS_OK, 1'b0},
    '{ROW_TYPED,   '{32'd0,         8'd128, 1'b0, 1'b1}, 32'h0,         1'b0, STATUS_PHASE, 1'b0},
    '{ROW_SETTINGS, '{32'd0, 8'd0, 1'b0, 1'b0},          32'hFFFF_FFFF, 1'b1, STATUS_OK, 1'b0},
    '{ROW_TYPED,   '{32'hFFFF_FFFF, 8'd0,   1'b0, 1'b1}, 32'h0000_0000, 1'b0, STATUS_OK, 1'b1},
    '{ROW_PREDICT, '{32'hFFFF_FFFE, 8'd21,  1'b1, 1'b0}, 32'h0,         1'b0, STATUS_OK, 1'b0},
    '{ROW_TYPED,   '{32'd1,         8'd3,   1'b0, 1'b0}, 32'h0000_0001, 1'b0, STATUS_OK, 1'b0},
    '{ROW_SETTINGS, '{32'd0, 8'd0, 1'b0, 1'b0},          32'd1,         1'b0, STATUS_OK, 1'b0},
    '{ROW_TYPED,   '{32'hDEAD_BEEF, 8'd0,   1'b1, 1'b1}, 32'h0000_0000, 1'b0, STATUS_NO_LATCH, 1'b0},
    '{ROW_PREDICT, '{32'd7,         8'd30,  1'b0, 1'b0}, 32'h0,         1'b0, STATUS_OK, 1'b0},
    '{ROW_SETTINGS, '{32'd0, 8'd0, 1'b0, 1'b0},          32'd3,         1'b1, STATUS_OK, 1'b0},
    '{ROW_PREDICT, '{32'd2,         8'd7,   1'b1, 1'b1}, 32'h0,         1'b0, STATUS_OK, 1'b0},
    '{ROW_PREDICT, '{32'hFFFF_FFFF, 8'd31,  1'b1, 1'b1}, 32'h0,         1'b0, STATUS_OK, 1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dtfb_in_if  req_if ();
  dtfb_out_if byte_if ();

  dds_tuning_frame_builder i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in      (req_if),
    .out     (byte_if)
  );

  // Local copy of the two registers, updated once a write has landed.
  logic [FREQ_W-1:0] ref_clk_hz  = SYSCLK_RESET;
  logic              latch_wired = LATCH_PIN_RESET;

  frame_item_t pending_bytes [$];
  int          mismatches = 0;
  bit          calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [FREQ_W-1:0] tuning_word(logic [FREQ_W-1:0] freq);
    logic [2*FREQ_W-1:0] num;
    num = {freq, {FREQ_W{1'b0}}};
    if (ref_clk_hz == '0) return '1;
    return FREQ_W'(num / {{FREQ_W{1'b0}}, ref_clk_hz});
  endfunction

  function automatic logic [BYTE_W-1:0] control_byte(request_t r);
    return {r.phase_code[PHASE_W-1:0], r.pd_flag, 2'b00};
  endfunction

  function automatic void push_frame(logic [FREQ_W-1:0] word, logic [BYTE_W-1:0] ctrl,
                                     logic pulse, logic [STATUS_W-1:0] st);
    for (int k = 0; k < FRAME_BYTES - 1; k++) begin
      pending_bytes.push_back(frame_item_t'{word[BYTE_W*k +: BYTE_W], 1'b0, 1'b0, STATUS_OK});
    end
    pending_bytes.push_back(frame_item_t'{ctrl, 1'b1, pulse, st});
  endfunction

  function automatic void push_phase_error();
    pending_bytes.push_back(frame_item_t'{8'd0, 1'b1, 1'b0, STATUS_PHASE});
  endfunction

  function automatic void predict_frame(request_t r);
    logic                pulse;
    logic [STATUS_W-1:0] st;
    pulse = r.latch_request && latch_wired;
    st    = (r.latch_request && !latch_wired) ? STATUS_NO_LATCH : STATUS_OK;
    if (r.phase_code > PHASE_MAX) begin
      push_phase_error();
    end else begin
      push_frame(tuning_word(r.target_freq), control_byte(r), pulse, st);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  // Returns in the time step of the edge at which the item is accepted.
  task automatic send_request(request_t r);
    while (!calm && $urandom_range(99) < 23) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.target_freq   <= r.target_freq;
    req_if.phase_code    <= r.phase_code;
    req_if.pd_flag       <= r.pd_flag;
    req_if.latch_request <= r.latch_request;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic drain_frames();
    req_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back, then reads them back.
  task automatic apply_settings(logic [FREQ_W-1:0] clk_hz, logic pin);
    logic [APB_ADDR_W-1:0] addr [4];
    logic                  wr   [4];
    logic [APB_DATA_W-1:0] data [4];
    addr = '{3'd0, 3'd4, 3'd0, 3'd4};
    wr   = '{1'b1, 1'b1, 1'b0, 1'b0};
    data = '{clk_hz, {31'd0, pin}, clk_hz, {31'd0, pin}};
    for (int k = 0; k < 4; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr[k];
      paddr   <= addr[k];
      pwdata  <= wr[k] ? data[k] : '0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (!wr[k] && prdata !== data[k]) begin
        report_mismatch("register read-back", data[k], prdata);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ref_clk_hz  = clk_hz;
    latch_wired = pin;
  endtask

  function automatic request_t random_request();
    request_t r;
    case ($urandom_range(5))
      0:       r.target_freq = $urandom;
      1:       r.target_freq = $urandom_range(1000);
      2:       r.target_freq = ref_clk_hz + $urandom_range(4) - 2;
      3:       r.target_freq = (ref_clk_hz >> 1) + $urandom_range(4) - 2;
      4:       r.target_freq = 32'hFFFF_FFFF - $urandom_range(3);
      default: r.target_freq = $urandom >> $urandom_range(31);
    endcase
    // Most items carry a valid phase so that full frames dominate.
    if ($urandom_range(99) < 80) r.phase_code = PHASE_IN_W'($urandom_range(31));
    else                         r.phase_code = PHASE_IN_W'($urandom_range(255, 32));
    r.pd_flag       = 1'($urandom_range(1));
    r.latch_request = 1'($urandom_range(1));
    return r;
  endfunction

  initial begin : byte_sink
    byte_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      byte_if.ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin : byte_check
    frame_item_t want;
    if (!rst && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected frame byte", 32'd0, 32'(byte_if.frame_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (byte_if.frame_byte !== want.frame_byte)
          report_mismatch("frame_byte", 32'(want.frame_byte), 32'(byte_if.frame_byte));
        if (byte_if.last_byte !== want.last_byte)
          report_mismatch("last_byte", 32'(want.last_byte), 32'(byte_if.last_byte));
        if (byte_if.pulse_latch !== want.pulse_latch)
          report_mismatch("pulse_latch", 32'(want.pulse_latch), 32'(byte_if.pulse_latch));
        if (byte_if.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(byte_if.status));
      end
    end
  end

  initial begin : stimulus
    logic [FREQ_W-1:0] clk_hz;
    logic              pin;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_if.valid         <= 1'b0;
    req_if.target_freq   <= '0;
    req_if.phase_code    <= '0;
    req_if.pd_flag       <= 1'b0;
    req_if.latch_request <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_SETTINGS: begin
          drain_frames();
          apply_settings(DIRECTED[i].word, DIRECTED[i].pin);
        end
        ROW_TYPED: begin
          send_request(DIRECTED[i].req);
          if (DIRECTED[i].last_status == STATUS_PHASE) begin
            push_phase_error();
          end else begin
            push_frame(DIRECTED[i].word, control_byte(DIRECTED[i].req),
                       DIRECTED[i].last_pulse, DIRECTED[i].last_status);
          end
        end
        default: begin
          send_request(DIRECTED[i].req);
          predict_frame(DIRECTED[i].req);
        end
      endcase
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_frames();
      case (p)
        0:       begin clk_hz = $urandom_range(200000000, 1000); pin = 1'($urandom_range(1)); end
        1:       begin clk_hz = $urandom_range(16, 1);           pin = 1'b1; end
        2:       begin clk_hz = '0;                              pin = 1'($urandom_range(1)); end
        3:       begin clk_hz = $urandom;                        pin = 1'b1; end
        4:       begin clk_hz = 32'hFFFF_FFFF;                   pin = 1'b0; end
        default: begin clk_hz = SYSCLK_RESET;                    pin = LATCH_PIN_RESET; end
      endcase
      apply_settings(clk_hz, pin);
      // One phase runs with neither side stalling.
      calm = (p == 3);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        request_t r;
        r = random_request();
        // Let the pipeline empty completely once in the middle of a phase.
        if (p == 1 && n == RAND_PER_PHASE / 2) drain_frames();
        send_request(r);
        predict_frame(r);
      end
    end

    drain_frames();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
